// ----- src/tfr_pkg.sv -----
// Package for the typed frame receiver: sizes, codes, enums and the structs
// passed between the configuration block, the parser core and the top level.
// No dependencies.
`default_nettype none

package tfr_pkg;

    // payload buffer sizing
    localparam int MAX_DATA_BYTES = 32;
    localparam int STORE_DEPTH    = MAX_DATA_BYTES + 1;
    localparam int ADDR_W         = $clog2(STORE_DEPTH);
    localparam int CNT_W          = $clog2(STORE_DEPTH + 1);
    localparam int INDEX_W        = 6;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;

    // input item codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_ERROR   = 2'd1;
    localparam logic [1:0] KIND_HEART   = 2'd2;
    localparam logic [1:0] KIND_LINK    = 2'd3;

    // frame types
    localparam logic [2:0] TYPE_HEARTBEAT = 3'd0;
    localparam logic [2:0] TYPE_STATUS    = 3'd1;
    localparam logic [2:0] TYPE_CONTROL   = 3'd2;
    localparam logic [2:0] TYPE_BAUDRATE  = 3'd3;
    localparam logic [2:0] TYPE_DATA      = 3'd4;

    // error codes
    localparam logic [1:0] ERR_CHECKSUM = 2'd0;
    localparam logic [1:0] ERR_HEADER   = 2'd1;
    localparam logic [1:0] ERR_LENGTH   = 2'd2;
    localparam logic [1:0] ERR_TIMEOUT  = 2'd3;

    // fixed payload lengths
    localparam logic [CNT_W-1:0] LEN_BAUDRATE = CNT_W'(4);
    localparam logic [CNT_W-1:0] LEN_SHORT    = CNT_W'(1);

    // register reset values
    localparam logic [7:0]  RST_CODE_HEARTBEAT = 8'd0;
    localparam logic [7:0]  RST_CODE_STATUS    = 8'd1;
    localparam logic [7:0]  RST_CODE_CONTROL   = 8'd2;
    localparam logic [7:0]  RST_CODE_BAUDRATE  = 8'd3;
    localparam logic [7:0]  RST_CODE_DATA      = 8'd4;
    localparam logic [15:0] RST_READ_TIMEOUT   = 16'd1000;
    localparam logic [15:0] RST_LINK_TIMEOUT   = 16'd1000;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CODE_HEARTBEAT = 3'd0,
        CFG_CODE_STATUS    = 3'd1,
        CFG_CODE_CONTROL   = 3'd2,
        CFG_CODE_BAUDRATE  = 3'd3,
        CFG_CODE_DATA      = 3'd4,
        CFG_READ_TIMEOUT   = 3'd5,
        CFG_LINK_TIMEOUT   = 3'd6
    } t_cfg_idx;

    // parse phases
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_FIXED,
        PH_LEN,
        PH_DATA,
        PH_CHECK
    } t_phase;

    // result sequencer states
    typedef enum logic [1:0] {
        ST_READY,
        ST_EVENTS,
        ST_RD,
        ST_WAIT
    } t_state;

    typedef struct packed {
        logic [7:0]  code_heartbeat;
        logic [7:0]  code_status;
        logic [7:0]  code_control;
        logic [7:0]  code_baudrate;
        logic [7:0]  code_data;
        logic [15:0] read_timeout_ms;
        logic [15:0] link_timeout_ms;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         event_kind;
        logic [2:0]         frame_type;
        logic [7:0]         data_byte;
        logic [INDEX_W-1:0] byte_index;
        logic [1:0]         error_code;
        logic               last;
    } t_result;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

endpackage

`default_nettype wire

// ----- src/tfr_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
`default_nettype none

module tfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 33
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read, read data holds while re is low
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- src/tfr_cfg.sv -----
// Configuration register file for the frame receiver: header codes and timeouts.
// Depends on tfr_pkg.
`default_nettype none

module tfr_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [tfr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [tfr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output tfr_pkg::t_cfg                        o_cfg
);

    tfr_pkg::t_cfg r_cfg;
    tfr_pkg::t_cfg n_cfg;

    // register decode, indexes past the list are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (tfr_pkg::t_cfg_idx'(i_cfg_index))
                tfr_pkg::CFG_CODE_HEARTBEAT: n_cfg.code_heartbeat = i_cfg_data[7:0];
                tfr_pkg::CFG_CODE_STATUS:    n_cfg.code_status    = i_cfg_data[7:0];
                tfr_pkg::CFG_CODE_CONTROL:   n_cfg.code_control   = i_cfg_data[7:0];
                tfr_pkg::CFG_CODE_BAUDRATE:  n_cfg.code_baudrate  = i_cfg_data[7:0];
                tfr_pkg::CFG_CODE_DATA:      n_cfg.code_data      = i_cfg_data[7:0];
                tfr_pkg::CFG_READ_TIMEOUT:   n_cfg.read_timeout_ms = i_cfg_data;
                tfr_pkg::CFG_LINK_TIMEOUT:   n_cfg.link_timeout_ms = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.code_heartbeat  <= tfr_pkg::RST_CODE_HEARTBEAT;
            r_cfg.code_status     <= tfr_pkg::RST_CODE_STATUS;
            r_cfg.code_control    <= tfr_pkg::RST_CODE_CONTROL;
            r_cfg.code_baudrate   <= tfr_pkg::RST_CODE_BAUDRATE;
            r_cfg.code_data       <= tfr_pkg::RST_CODE_DATA;
            r_cfg.read_timeout_ms <= tfr_pkg::RST_READ_TIMEOUT;
            r_cfg.link_timeout_ms <= tfr_pkg::RST_LINK_TIMEOUT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

endmodule

`default_nettype wire

// ----- src/tfr_core.sv -----
// Frame parser and result sequencer: updates the parse state per beat, writes
// payload bytes to the buffer RAM and replays them from it after a good check byte.
// Depends on tfr_pkg; drives a tfr_ram instance through a t_ram_req struct.
`default_nettype none

module tfr_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tfr_pkg::t_cfg     i_cfg,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_opcode,
    input  wire logic [7:0]        i_rx_byte,
    output tfr_pkg::t_ram_req      o_ram,
    input  wire logic [7:0]        i_ram_rdata,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output tfr_pkg::t_result       o_out
);

    localparam logic [15:0] TIMER_MAX = 16'hFFFF;

    // parse state
    tfr_pkg::t_phase                 r_phase, n_phase;
    logic [2:0]                      r_type, n_type;
    logic [tfr_pkg::CNT_W-1:0]       r_bytes, n_bytes;
    logic [tfr_pkg::CNT_W-1:0]       r_exp, n_exp;
    logic [7:0]                      r_xor, n_xor;
    logic [15:0]                     r_ptimer, n_ptimer;
    logic [15:0]                     r_ltimer, n_ltimer;
    logic                            r_lost, n_lost;

    // result sequencing
    tfr_pkg::t_state                 r_state, n_state;
    tfr_pkg::t_result                r_ev0, n_ev0;
    tfr_pkg::t_result                r_ev1, n_ev1;
    logic                            r_ev1_v, n_ev1_v;
    logic [tfr_pkg::CNT_W-1:0]       r_idx, n_idx;
    logic [tfr_pkg::CNT_W-1:0]       r_cnt, n_cnt;
    tfr_pkg::t_result                r_out, n_out;
    logic                            r_out_v, n_out_v;

    logic                            accept;
    logic                            out_free;
    logic [15:0]                     ptimer_inc;
    logic [15:0]                     ltimer_inc;
    logic [tfr_pkg::CNT_W-1:0]       bytes_inc;
    logic                            ev_a_v, ev_b_v, run_v;
    tfr_pkg::t_result                ev_a, ev_b;

    // buffer RAM request fields
    logic                            ram_we;
    logic [tfr_pkg::ADDR_W-1:0]      ram_waddr;
    logic [7:0]                      ram_wdata;
    logic                            ram_re;
    logic [tfr_pkg::ADDR_W-1:0]      ram_raddr;

    assign o_in_ready = (r_state == tfr_pkg::ST_READY);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_v || i_out_ready;
    assign ptimer_inc = (r_ptimer == TIMER_MAX) ? r_ptimer : r_ptimer + 16'd1;
    assign ltimer_inc = (r_ltimer == TIMER_MAX) ? r_ltimer : r_ltimer + 16'd1;
    assign bytes_inc  = r_bytes + tfr_pkg::CNT_W'(1);

    // per-beat parse step: next parse state, buffer write and up to two events
    always_comb begin
        n_phase  = r_phase;
        n_type   = r_type;
        n_bytes  = r_bytes;
        n_exp    = r_exp;
        n_xor    = r_xor;
        n_ptimer = r_ptimer;
        n_ltimer = r_ltimer;
        n_lost   = r_lost;
        ev_a_v   = 1'b0;
        ev_b_v   = 1'b0;
        run_v    = 1'b0;
        ev_a     = '0;
        ev_b     = '0;
        ram_we    = 1'b0;
        ram_waddr = r_bytes[tfr_pkg::ADDR_W-1:0];
        ram_wdata = i_rx_byte;

        if (accept && i_opcode == tfr_pkg::OP_BYTE) begin
            unique case (r_phase)
                tfr_pkg::PH_IDLE: begin
                    n_xor   = i_rx_byte;
                    n_bytes = '0;
                    if (i_rx_byte == i_cfg.code_heartbeat) begin
                        n_type   = tfr_pkg::TYPE_HEARTBEAT;
                        n_exp    = '0;
                        n_phase  = tfr_pkg::PH_CHECK;
                        n_ptimer = '0;
                    end else if (i_rx_byte == i_cfg.code_status) begin
                        n_type   = tfr_pkg::TYPE_STATUS;
                        n_exp    = tfr_pkg::LEN_SHORT;
                        n_phase  = tfr_pkg::PH_FIXED;
                        n_ptimer = '0;
                    end else if (i_rx_byte == i_cfg.code_control) begin
                        n_type   = tfr_pkg::TYPE_CONTROL;
                        n_exp    = tfr_pkg::LEN_SHORT;
                        n_phase  = tfr_pkg::PH_FIXED;
                        n_ptimer = '0;
                    end else if (i_rx_byte == i_cfg.code_baudrate) begin
                        n_type   = tfr_pkg::TYPE_BAUDRATE;
                        n_exp    = tfr_pkg::LEN_BAUDRATE;
                        n_phase  = tfr_pkg::PH_FIXED;
                        n_ptimer = '0;
                    end else if (i_rx_byte == i_cfg.code_data) begin
                        n_type   = tfr_pkg::TYPE_DATA;
                        n_exp    = '0;
                        n_phase  = tfr_pkg::PH_LEN;
                        n_ptimer = '0;
                    end else begin
                        ev_a_v            = 1'b1;
                        ev_a.event_kind   = tfr_pkg::KIND_ERROR;
                        ev_a.frame_type   = tfr_pkg::TYPE_HEARTBEAT;
                        ev_a.error_code   = tfr_pkg::ERR_HEADER;
                    end
                end
                tfr_pkg::PH_FIXED, tfr_pkg::PH_DATA: begin
                    ram_we  = (r_bytes < tfr_pkg::CNT_W'(tfr_pkg::STORE_DEPTH));
                    n_bytes = bytes_inc;
                    n_xor   = r_xor ^ i_rx_byte;
                    if (bytes_inc >= r_exp) begin
                        n_phase  = tfr_pkg::PH_CHECK;
                        n_ptimer = '0;
                    end
                end
                tfr_pkg::PH_LEN: begin
                    n_xor    = r_xor ^ i_rx_byte;
                    n_ptimer = '0;
                    if (i_rx_byte > 8'(tfr_pkg::MAX_DATA_BYTES)) begin
                        ev_a_v          = 1'b1;
                        ev_a.event_kind = tfr_pkg::KIND_ERROR;
                        ev_a.frame_type = r_type;
                        ev_a.error_code = tfr_pkg::ERR_LENGTH;
                        n_phase         = tfr_pkg::PH_IDLE;
                    end else begin
                        ram_we      = 1'b1;
                        ram_waddr   = '0;
                        n_bytes     = tfr_pkg::CNT_W'(1);
                        n_exp       = tfr_pkg::CNT_W'(i_rx_byte) + tfr_pkg::CNT_W'(1);
                        n_phase     = (i_rx_byte == 8'd0) ? tfr_pkg::PH_CHECK
                                                          : tfr_pkg::PH_DATA;
                    end
                end
                tfr_pkg::PH_CHECK: begin
                    n_phase  = tfr_pkg::PH_IDLE;
                    n_ptimer = '0;
                    if (i_rx_byte != r_xor) begin
                        ev_a_v          = 1'b1;
                        ev_a.event_kind = tfr_pkg::KIND_ERROR;
                        ev_a.frame_type = r_type;
                        ev_a.error_code = tfr_pkg::ERR_CHECKSUM;
                    end else begin
                        n_ltimer = '0;
                        n_lost   = 1'b0;
                        if (r_type == tfr_pkg::TYPE_HEARTBEAT) begin
                            ev_a_v          = 1'b1;
                            ev_a.event_kind = tfr_pkg::KIND_HEART;
                        end else begin
                            run_v = (r_bytes != '0);
                        end
                    end
                end
                default: ;
            endcase
        end else if (accept) begin
            // tick: phase timeout first, then link loss
            if (r_phase != tfr_pkg::PH_IDLE) begin
                n_ptimer = ptimer_inc;
                if (ptimer_inc >= i_cfg.read_timeout_ms) begin
                    ev_a_v          = 1'b1;
                    ev_a.event_kind = tfr_pkg::KIND_ERROR;
                    ev_a.frame_type = r_type;
                    ev_a.error_code = tfr_pkg::ERR_TIMEOUT;
                    n_phase         = tfr_pkg::PH_IDLE;
                    n_ptimer        = '0;
                end
            end
            n_ltimer = ltimer_inc;
            if (!r_lost && ltimer_inc >= i_cfg.link_timeout_ms) begin
                n_lost          = 1'b1;
                ev_b_v          = 1'b1;
                ev_b.event_kind = tfr_pkg::KIND_LINK;
            end
        end
    end

    // result sequencer: queued events, then the buffered run read back from RAM
    always_comb begin
        n_state  = r_state;
        n_ev0    = r_ev0;
        n_ev1    = r_ev1;
        n_ev1_v  = r_ev1_v;
        n_idx    = r_idx;
        n_cnt    = r_cnt;
        n_out    = r_out;
        n_out_v  = r_out_v && !i_out_ready;
        ram_re    = 1'b0;
        ram_raddr = r_idx[tfr_pkg::ADDR_W-1:0];

        unique case (r_state)
            tfr_pkg::ST_READY: begin
                if (ev_a_v) begin
                    n_ev0      = ev_a;
                    n_ev0.last = !ev_b_v;
                    n_ev1      = ev_b;
                    n_ev1.last = 1'b1;
                    n_ev1_v    = ev_b_v;
                    n_state    = tfr_pkg::ST_EVENTS;
                end else if (ev_b_v) begin
                    n_ev0      = ev_b;
                    n_ev0.last = 1'b1;
                    n_ev1_v    = 1'b0;
                    n_state    = tfr_pkg::ST_EVENTS;
                end else if (run_v) begin
                    n_idx   = '0;
                    n_cnt   = r_bytes;
                    n_state = tfr_pkg::ST_RD;
                end
            end
            tfr_pkg::ST_EVENTS: begin
                if (out_free) begin
                    n_out   = r_ev0;
                    n_out_v = 1'b1;
                    if (r_ev1_v) begin
                        n_ev0   = r_ev1;
                        n_ev1_v = 1'b0;
                    end else begin
                        n_state = tfr_pkg::ST_READY;
                    end
                end
            end
            tfr_pkg::ST_RD: begin
                ram_re  = 1'b1;
                n_state = tfr_pkg::ST_WAIT;
            end
            tfr_pkg::ST_WAIT: begin
                if (out_free) begin
                    n_out.event_kind = tfr_pkg::KIND_PAYLOAD;
                    n_out.frame_type = r_type;
                    n_out.data_byte  = i_ram_rdata;
                    n_out.byte_index = tfr_pkg::INDEX_W'(r_idx);
                    n_out.error_code = tfr_pkg::ERR_CHECKSUM;
                    n_out.last       = (r_idx + tfr_pkg::CNT_W'(1) == r_cnt);
                    n_out_v          = 1'b1;
                    if (r_idx + tfr_pkg::CNT_W'(1) == r_cnt) begin
                        n_state = tfr_pkg::ST_READY;
                    end else begin
                        n_idx   = r_idx + tfr_pkg::CNT_W'(1);
                        n_state = tfr_pkg::ST_RD;
                    end
                end
            end
            default: n_state = tfr_pkg::ST_READY;
        endcase
    end

    assign o_ram = '{we: ram_we, waddr: ram_waddr, wdata: ram_wdata,
                     re: ram_re, raddr: ram_raddr};

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= tfr_pkg::PH_IDLE;
            r_type   <= '0;
            r_bytes  <= '0;
            r_exp    <= '0;
            r_xor    <= '0;
            r_ptimer <= '0;
            r_ltimer <= '0;
            r_lost   <= 1'b0;
            r_state  <= tfr_pkg::ST_READY;
            r_ev1_v  <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_type   <= n_type;
            r_bytes  <= n_bytes;
            r_exp    <= n_exp;
            r_xor    <= n_xor;
            r_ptimer <= n_ptimer;
            r_ltimer <= n_ltimer;
            r_lost   <= n_lost;
            r_state  <= n_state;
            r_ev1_v  <= n_ev1_v;
            r_out_v  <= n_out_v;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ev0 <= n_ev0;
        r_ev1 <= n_ev1;
        r_idx <= n_idx;
        r_cnt <= n_cnt;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// ----- src/typed_frame_receiver_xor.sv -----
// Typed frame receiver with XOR check byte. One beat is taken per cycle while the
// result sequencer is idle; an error, heartbeat or link-lost result is held in an
// event register and then registered at the output once the output is free (a
// tick with two events gives them one after the other, the timeout first). A good
// check byte replays the buffered payload from the RAM, read then register for each
// result, up to 33 results; the next beat is taken once the last one is registered.
// Reset is synchronous: parser idle, timers clear, registers at defaults; the
// payload RAM is not cleared and needs no clearing pass.
`default_nettype none

module typed_frame_receiver_xor (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [tfr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [tfr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic                            i_opcode,
    input  wire logic [7:0]                      i_rx_byte,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [1:0]                           o_event_kind,
    output logic [2:0]                           o_frame_type,
    output logic [7:0]                           o_data_byte,
    output logic [tfr_pkg::INDEX_W-1:0]          o_byte_index,
    output logic [1:0]                           o_error_code,
    output logic                                 o_last
);

    tfr_pkg::t_cfg     cfg;
    tfr_pkg::t_ram_req ram_req;
    tfr_pkg::t_result  result;
    logic [7:0]        ram_rdata;

    // configuration registers
    tfr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // payload buffer
    tfr_ram #(
        .WIDTH (8),
        .DEPTH (tfr_pkg::STORE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    // parser and result sequencer
    tfr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .i_rx_byte   (i_rx_byte),
        .o_ram       (ram_req),
        .i_ram_rdata (ram_rdata),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (result)
    );

    assign o_event_kind = result.event_kind;
    assign o_frame_type = result.frame_type;
    assign o_data_byte  = result.data_byte;
    assign o_byte_index = result.byte_index;
    assign o_error_code = result.error_code;
    assign o_last       = result.last;

    // result consistency checks
    a_payload_not_heartbeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_kind == tfr_pkg::KIND_PAYLOAD
        |-> o_frame_type != tfr_pkg::TYPE_HEARTBEAT)
        else $error("payload result tagged as heartbeat frame");

    a_error_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_kind == tfr_pkg::KIND_ERROR
        |-> o_data_byte == 8'd0 && o_byte_index == '0)
        else $error("error result carries payload fields");

    a_link_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_kind == tfr_pkg::KIND_LINK |-> o_last)
        else $error("link lost result not last of its beat");

    a_heart_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_kind == tfr_pkg::KIND_HEART |-> o_last)
        else $error("heartbeat result not last of its beat");

endmodule

`default_nettype wire
